// ----- hw/rtl/crs_pkg.sv -----
// Shared constants and types for the circle pair overlap resolver.
// No dependencies.
`timescale 1ns / 1ps
package crs_pkg;

  localparam int RAD_W      = 16;
  localparam int DIST_W     = RAD_W + 1;
  localparam int QUO_W      = RAD_W;
  localparam int NUM_W      = 2 * DIST_W;
  localparam int DIV_W      = DIST_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef struct packed {
    logic touching;
    logic coincident;
  } crs_flags_t;

  // touching sits in bit 0
  typedef struct packed {
    logic clipped;
    logic coincident;
    logic touching;
  } crs_result_t;

endpackage

// ----- hw/rtl/circle_pair_overlap_resolver.sv -----
// Top level of the circle pair overlap resolver: stream ports, front part,
// queue and back part. Depends on crs_pkg, crs_front, crs_fifo, crs_back.
`timescale 1ns / 1ps
// Takes one circle pair per cycle and returns one result per pair, in order.
// Positions are signed fixed point; distance is the truncated integer root
// of dx*dx + dy*dy, and touching pairs that are not coincident are pushed
// apart by half the overlap along the centre line, quotients truncated toward
// zero, results saturated. The front has the input, squares and sum
// registers and the square root pipeline (one root bit per stage), then
// the four-entry queue, then the back (multiply stage, one quotient bit per
// divider stage, output register). Throughput is one pair per cycle while
// the queue has room; the front keeps accepting while results wait on the
// output until the queue fills.
module circle_pair_overlap_resolver
  import crs_pkg::*;
#(
  parameter int POS_BITS = 25
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // first_x, first_y, first_radius, second_x, second_y, second_radius
  input  logic [((4*POS_BITS+2*RAD_W+7)/8)*8-1:0] in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // new_first_x, new_first_y, new_second_x, new_second_y
  output logic [((4*POS_BITS+7)/8)*8-1:0]         out_tdata,
  // touching, coincident, clipped
  output logic [2:0]                              out_tuser
);

  localparam int P     = POS_BITS;
  localparam int OUT_W = ((4*P+7)/8)*8;
  localparam int QW    = 4*P + 2 + 4*DIST_W + 2;

  logic                 f_valid, q_full, q_valid, q_pop;
  logic [4*P-1:0]       f_pos, q_pos, out_pos;
  logic [1:0]           f_neg, q_neg;
  logic [DIST_W-1:0]    f_mx, f_my, f_ov, f_dist;
  logic [DIST_W-1:0]    q_mx, q_my, q_ov, q_dist;
  crs_flags_t           f_flags, q_flags;
  crs_result_t          out_res;
  logic [QW-1:0]        q_din, q_dout;

  crs_front #(.POS_BITS(P)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_ax    (in_tdata[P-1:0]),
    .in_ay    (in_tdata[2*P-1:P]),
    .in_ar    (in_tdata[2*P+RAD_W-1:2*P]),
    .in_bx    (in_tdata[3*P+RAD_W-1:2*P+RAD_W]),
    .in_by    (in_tdata[4*P+RAD_W-1:3*P+RAD_W]),
    .in_br    (in_tdata[4*P+2*RAD_W-1:4*P+RAD_W]),
    .room     (!q_full),
    .f_valid  (f_valid),
    .f_pos    (f_pos),
    .f_neg    (f_neg),
    .f_mx     (f_mx),
    .f_my     (f_my),
    .f_ov     (f_ov),
    .f_dist   (f_dist),
    .f_flags  (f_flags)
  );

  assign q_din = {f_pos, f_neg, f_mx, f_my, f_ov, f_dist, f_flags};

  crs_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign {q_pos, q_neg, q_mx, q_my, q_ov, q_dist, q_flags} = q_dout;

  crs_back #(.POS_BITS(P)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_pos     (q_pos),
    .q_neg     (q_neg),
    .q_mx      (q_mx),
    .q_my      (q_my),
    .q_ov      (q_ov),
    .q_dist    (q_dist),
    .q_flags   (q_flags),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pos   (out_pos),
    .out_res   (out_res)
  );

  assign out_tdata = OUT_W'(out_pos);
  assign out_tuser = out_res;

  a_coinc_touch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("coincident result without touching");

  a_clip_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[0] && !out_tuser[1])
    else $error("clipped result on a pair that did not move");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_valid && !in_tready)
    else $error("queue full without data or front still accepting");

endmodule

// ----- hw/rtl/crs_fifo.sv -----
// Short register queue between the front and back parts of the resolver.
// Depends on crs_pkg.
`timescale 1ns / 1ps
module crs_fifo
  import crs_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  logic [W-1:0]     mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- hw/rtl/crs_front.sv -----
// Front part: centre difference, squares and pipelined integer square root,
// then classification into touching / coincident with overlap. Uses crs_pkg.
`timescale 1ns / 1ps
module crs_front
  import crs_pkg::*;
#(
  parameter int POS_BITS = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_BITS-1:0]   in_ax,
  input  logic [POS_BITS-1:0]   in_ay,
  input  logic [RAD_W-1:0]      in_ar,
  input  logic [POS_BITS-1:0]   in_bx,
  input  logic [POS_BITS-1:0]   in_by,
  input  logic [RAD_W-1:0]      in_br,
  input  logic                  room,
  output logic                  f_valid,
  output logic [4*POS_BITS-1:0] f_pos,
  output logic [1:0]            f_neg,
  output logic [DIST_W-1:0]     f_mx,
  output logic [DIST_W-1:0]     f_my,
  output logic [DIST_W-1:0]     f_ov,
  output logic [DIST_W-1:0]     f_dist,
  output crs_flags_t            f_flags
);

  localparam int P      = POS_BITS;
  localparam int D_W    = P + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int ROOT_W = D_W;
  localparam int REM_W  = P + 3;
  localparam int CW     = 4 * P + 3 * DIST_W + 2;
  localparam int NST    = ROOT_W + 3;

  logic                adv;
  logic [NST-1:0]      vld_r;
  logic signed [D_W-1:0] dx, dy;
  logic [D_W-1:0]      mx, my;

  logic [4*P-1:0]      a_pos_r;
  logic [DIST_W-1:0]   a_rsum_r;
  logic [1:0]          a_neg_r;
  logic [D_W-1:0]      a_mx_r, a_my_r;

  logic [CW-1:0]       b_pl_r;
  logic [SQ_W-1:0]     b_sqx_r, b_sqy_r;

  logic [CW-1:0]       pl_r   [0:ROOT_W];
  logic [SQ_W-1:0]     sq_r   [0:ROOT_W];
  logic [REM_W-1:0]    rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]   root_r [0:ROOT_W];

  logic [ROOT_W-1:0]   cdist;
  logic [DIST_W-1:0]   rsum;

  assign adv      = room;
  assign in_ready = adv;

  assign dx = $signed({in_ax[P-1], in_ax}) - $signed({in_bx[P-1], in_bx});
  assign dy = $signed({in_ay[P-1], in_ay}) - $signed({in_by[P-1], in_by});
  assign mx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
  assign my = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pos_r  <= {in_by, in_bx, in_ay, in_ax};
      a_rsum_r <= DIST_W'(in_ar) + DIST_W'(in_br);
      a_neg_r  <= {dy[D_W-1], dx[D_W-1]};
      a_mx_r   <= mx;
      a_my_r   <= my;
      b_pl_r   <= {a_pos_r, a_rsum_r, a_neg_r, DIST_W'(a_mx_r), DIST_W'(a_my_r)};
      b_sqx_r  <= SQ_W'(a_mx_r) * SQ_W'(a_mx_r);
      b_sqy_r  <= SQ_W'(a_my_r) * SQ_W'(a_my_r);
      pl_r[0]   <= b_pl_r;
      sq_r[0]   <= b_sqx_r + b_sqy_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // one root bit per stage, MSB pair first
  for (genvar i = 1; i <= ROOT_W; i++) begin : g_sqrt
    logic [REM_W-1:0] remt, trial;
    logic             ge;
    assign remt  = {rem_r[i-1][REM_W-3:0], sq_r[i-1][SQ_W-1 -: 2]};
    assign trial = REM_W'({root_r[i-1], 2'b01});
    assign ge    = (remt >= trial);
    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[i]   <= pl_r[i-1];
        sq_r[i]   <= sq_r[i-1] << 2;
        rem_r[i]  <= ge ? REM_W'(remt - trial) : remt;
        root_r[i] <= {root_r[i-1][ROOT_W-2:0], ge};
      end
    end
  end

  assign cdist   = root_r[ROOT_W];
  assign rsum    = pl_r[ROOT_W][3*DIST_W+1 -: DIST_W];
  assign f_valid = vld_r[NST-1];
  assign f_pos   = pl_r[ROOT_W][CW-1 -: 4*P];
  assign f_neg   = pl_r[ROOT_W][2*DIST_W+1 -: 2];
  assign f_mx    = pl_r[ROOT_W][2*DIST_W-1 -: DIST_W];
  assign f_my    = pl_r[ROOT_W][DIST_W-1:0];
  assign f_dist  = DIST_W'(cdist);
  assign f_ov    = rsum - DIST_W'(cdist);
  assign f_flags.touching   = (cdist <= rsum);
  assign f_flags.coincident = (cdist == '0);

endmodule

// ----- hw/rtl/crs_back.sv -----
// Back part: push components by pipelined restoring division, then the
// position update with saturation and the output register. Uses crs_pkg.
`timescale 1ns / 1ps
module crs_back
  import crs_pkg::*;
#(
  parameter int POS_BITS = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [4*POS_BITS-1:0] q_pos,
  input  logic [1:0]            q_neg,
  input  logic [DIST_W-1:0]     q_mx,
  input  logic [DIST_W-1:0]     q_my,
  input  logic [DIST_W-1:0]     q_ov,
  input  logic [DIST_W-1:0]     q_dist,
  input  crs_flags_t            q_flags,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4*POS_BITS-1:0] out_pos,
  output crs_result_t           out_res
);

  localparam int P   = POS_BITS;
  localparam int E_W = P + 2;

  logic              adv;
  logic [QUO_W:0]    vld_r;
  logic              out_vld_r;
  logic [4*P-1:0]    out_pos_r;
  crs_result_t       out_res_r;

  logic [4*P-1:0]    pos_r [0:QUO_W];
  logic [1:0]        neg_r [0:QUO_W];
  crs_flags_t        flg_r [0:QUO_W];
  logic [DIV_W-1:0]  dv_r  [0:QUO_W];
  logic [NUM_W-1:0]  rx_r  [0:QUO_W];
  logic [NUM_W-1:0]  ry_r  [0:QUO_W];
  logic [QUO_W-1:0]  qx_r  [0:QUO_W];
  logic [QUO_W-1:0]  qy_r  [0:QUO_W];

  logic signed [E_W-1:0] qxe, qye, px, py;
  logic signed [E_W-1:0] sum [4];
  logic [P-1:0]      sat_v [4];
  logic [3:0]        clip;
  logic              move;
  logic [4*P-1:0]    pos_f;

  assign adv       = !out_vld_r || out_ready;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_vld_r;
  assign out_pos   = out_pos_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[QUO_W-1:0], q_valid};
      out_vld_r <= vld_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r[0] <= q_pos;
      neg_r[0] <= q_neg;
      flg_r[0] <= q_flags;
      dv_r[0]  <= {q_dist, 1'b0};
      rx_r[0]  <= NUM_W'(q_mx) * NUM_W'(q_ov);
      ry_r[0]  <= NUM_W'(q_my) * NUM_W'(q_ov);
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 1; j <= QUO_W; j++) begin : g_div
    localparam int B = QUO_W - j;
    logic [NUM_W-1:0] dsh;
    logic             gex, gey;
    assign dsh = NUM_W'(dv_r[j-1]) << B;
    assign gex = (rx_r[j-1] >= dsh);
    assign gey = (ry_r[j-1] >= dsh);
    always_ff @(posedge clk) begin
      if (adv) begin
        pos_r[j] <= pos_r[j-1];
        neg_r[j] <= neg_r[j-1];
        flg_r[j] <= flg_r[j-1];
        dv_r[j]  <= dv_r[j-1];
        rx_r[j]  <= gex ? NUM_W'(rx_r[j-1] - dsh) : rx_r[j-1];
        ry_r[j]  <= gey ? NUM_W'(ry_r[j-1] - dsh) : ry_r[j-1];
        qx_r[j]  <= qx_r[j-1] | (QUO_W'(gex) << B);
        qy_r[j]  <= qy_r[j-1] | (QUO_W'(gey) << B);
      end
    end
  end

  assign pos_f = pos_r[QUO_W];
  assign qxe   = $signed(E_W'(qx_r[QUO_W]));
  assign qye   = $signed(E_W'(qy_r[QUO_W]));
  assign px    = neg_r[QUO_W][0] ? -qxe : qxe;
  assign py    = neg_r[QUO_W][1] ? -qye : qye;
  assign move  = flg_r[QUO_W].touching && !flg_r[QUO_W].coincident;

  assign sum[0] = $signed({{2{pos_f[P-1]}}, pos_f[P-1:0]}) + px;
  assign sum[1] = $signed({{2{pos_f[2*P-1]}}, pos_f[2*P-1:P]}) + py;
  assign sum[2] = $signed({{2{pos_f[3*P-1]}}, pos_f[3*P-1:2*P]}) - px;
  assign sum[3] = $signed({{2{pos_f[4*P-1]}}, pos_f[4*P-1:3*P]}) - py;

  for (genvar k = 0; k < 4; k++) begin : g_sat
    assign clip[k]  = !((sum[k][E_W-1:P-1] == '0) || (sum[k][E_W-1:P-1] == '1));
    assign sat_v[k] = clip[k] ? {sum[k][E_W-1], {(P-1){~sum[k][E_W-1]}}}
                              : sum[k][P-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_r <= move ? {sat_v[3], sat_v[2], sat_v[1], sat_v[0]} : pos_f;
      out_res_r.touching   <= flg_r[QUO_W].touching;
      out_res_r.coincident <= flg_r[QUO_W].touching && flg_r[QUO_W].coincident;
      out_res_r.clipped    <= move && (|clip);
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench for circle_pair_overlap_resolver: directed and random circle pairs,
// predicted results compared in order. Depends on crs_pkg and the top level RTL.
`timescale 1ns / 1ps
module tb;
  import crs_pkg::*;

  localparam int PB = 25;
  localparam int IN_W = ((4*PB+2*RAD_W+7)/8)*8;
  localparam int OUT_W = ((4*PB+7)/8)*8;
  localparam int WD_LIMIT = 20000;
  localparam longint PMAX = (64'sd1 << (PB-1)) - 1;
  localparam longint PMIN = -PMAX - 1;

  typedef struct packed {
    logic [PB-1:0] ax, ay, bx, by;
    logic          touching, coincident, clipped;
  } sep_t;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tready, out_tvalid;
  logic [OUT_W-1:0] out_tdata;
  logic [2:0] out_tuser;

  sep_t pending_sep[$];
  int mismatches = 0;
  int watchdog = 0;
  int rdy_hold = 0;
  bit no_idle = 0;
  bit timed_out = 0;

  circle_pair_overlap_resolver #(.POS_BITS(PB)) u_dut (.*);

  initial forever #10 clk = ~clk;

  function automatic logic [63:0] isqrt(logic [64:0] v);
    logic [64:0] rem, root, trial;
    rem = 0; root = 0;
    for (int p = 32; p >= 0; p--) begin
      rem = (rem << 2) | ((v >> (2*p)) & 3);
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint sat(longint v, ref bit clip);
    if (v > PMAX) begin clip = 1; return PMAX; end
    if (v < PMIN) begin clip = 1; return PMIN; end
    return v;
  endfunction

  function automatic longint push_comp(longint d, longint ov, longint cdist);
    longint m, q;
    m = d < 0 ? -d : d;
    q = (m * ov) / (2 * cdist);
    return d < 0 ? -q : q;
  endfunction

  function automatic sep_t separate(logic [PB-1:0] ax, ay, logic [15:0] ar,
                                    logic [PB-1:0] bx, by, logic [15:0] br);
    longint sax, say, sbx, sby, dx, dy, cdist, rsum, ov, px, py;
    logic [64:0] sq;
    bit clip;
    sep_t r;
    sax = longint'($signed(ax)); say = longint'($signed(ay));
    sbx = longint'($signed(bx)); sby = longint'($signed(by));
    dx = sax - sbx; dy = say - sby;
    sq = 65'(dx*dx) + 65'(dy*dy);
    cdist = longint'(isqrt(sq));
    rsum = longint'(ar) + longint'(br);
    clip = 0;
    r.touching = cdist <= rsum;
    r.coincident = r.touching && cdist == 0;
    if (r.touching && cdist != 0) begin
      ov = rsum - cdist;
      px = push_comp(dx, ov, cdist);
      py = push_comp(dy, ov, cdist);
      sax = sat(sax + px, clip); say = sat(say + py, clip);
      sbx = sat(sbx - px, clip); sby = sat(sby - py, clip);
    end
    r.clipped = clip;
    r.ax = sax[PB-1:0]; r.ay = say[PB-1:0];
    r.bx = sbx[PB-1:0]; r.by = sby[PB-1:0];
    return r;
  endfunction

  task automatic send_pair(logic [PB-1:0] ax, ay, logic [15:0] ar,
                           logic [PB-1:0] bx, by, logic [15:0] br);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tdata <= IN_W'({br, by, bx, ar, ay, ax});
    in_tvalid <= 1;
    pending_sep = {pending_sep, separate(ax, ay, ar, bx, by, br)};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [PB-1:0] rpos();
    return PB'({$urandom, $urandom});
  endfunction

  // nearby pair, usually overlapping
  task automatic send_close(int span, int rmax);
    logic [PB-1:0] ax, ay;
    ax = rpos(); ay = rpos();
    send_pair(ax, ay, 16'($urandom_range(0, rmax)),
              ax + PB'($signed($urandom_range(0, 2*span)) - span),
              ay + PB'($signed($urandom_range(0, 2*span)) - span),
              16'($urandom_range(0, rmax)));
  endtask

  task automatic test_directed();
    logic [PB-1:0] mx, mn;
    mx = PB'(PMAX); mn = PB'(PMIN);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(mx, mx, 16'hffff, mx, mx, 16'hffff);
    send_pair(mn, mn, 16'hffff, mx, mx, 16'hffff);
    send_pair(mx, mn, 0, mn, mx, 0);
    send_pair(0, 0, 100, 300, 400, 400);
    send_pair(0, 0, 100, 300, 400, 399);
    send_pair(0, 0, 16'hffff, 1, 0, 16'hffff);
    send_pair(mx, 0, 16'hffff, PB'(mx - 10), 0, 16'hffff);
    send_pair(mn, 0, 16'hffff, PB'(mn + 10), 0, 16'hffff);
    send_pair(0, PB'(mx - 5), 16'hffff, 3, PB'(mx - 9), 16'hffff);
    send_pair(0, PB'(mn + 5), 16'hffff, PB'(-3), PB'(mn + 9), 16'hffff);
    send_pair(PB'(-7), PB'(-7), 50, PB'(-7), PB'(-7), 9);
    send_pair(1000, PB'(-2000), 16'h8000, PB'(-1000), 2000, 16'h8000);
    send_pair(0, 0, 16'hffff, 0, PB'(16'hffff * 2), 16'hffff);
    send_pair(0, 0, 16'hffff, 0, PB'(16'hffff * 2 + 1), 16'hffff);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_pair(rpos(), rpos(), 16'($urandom), rpos(), rpos(), 16'($urandom));
        1, 2: send_close(16, 65535);
        3: begin
          send_close(200000, 65535);
        end
        default: send_close(70000, 65535);
      endcase
    end
  endtask

  task automatic test_streaming(int n);
    no_idle = 1;
    for (int i = 0; i < n; i++) send_close(70000, 65535);
  endtask

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_tready <= rst_n;
      rdy_hold <= 0;
    end else if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
      if (rdy_hold == 1) out_tready <= 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 0;
      rdy_hold <= int'($urandom_range(1, 17));
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    sep_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ax = out_tdata[PB-1:0];
      got.ay = out_tdata[2*PB-1:PB];
      got.bx = out_tdata[3*PB-1:2*PB];
      got.by = out_tdata[4*PB-1:3*PB];
      {got.clipped, got.coincident, got.touching} = out_tuser;
      if (pending_sep.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h %b", out_tdata, out_tuser);
      end else begin
        want = pending_sep.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h t%b c%b k%b got %h %h %h %h t%b c%b k%b",
                     want.ax, want.ay, want.bx, want.by,
                     want.touching, want.coincident, want.clipped,
                     got.ax, got.ay, got.bx, got.by,
                     got.touching, got.coincident, got.clipped);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WD_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_streaming(100);
    in_tvalid <= 0;
    while (pending_sep.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
